/* hw/rtl/ksel_pkg.sv */
// Package with the shared widths, defaults, types and state codes of the rank selector.
package ksel_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int RANK_W        = 8;
  localparam int MAX_ITEMS_DEF = 128;
  localparam logic [RANK_W-1:0] RANK_RESET = 8'd1;

  // Control of one step of the cell chain.
  typedef struct packed {
    logic insert;  // Sorted insertion of the broadcast word.
    logic shift;   // Every cell takes the word of its right neighbor.
    logic clear;   // Every cell becomes empty.
  } ksel_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD   = 2'b01,
    ST_SELECT = 2'b10
  } ksel_state_t;

endpackage

/* hw/rtl/ksel_cell.sv */
// One cell of the sorted chain: holds one word and its occupied flag.
module ksel_cell import ksel_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ksel_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] new_word,
  input  logic                       left_gt,
  input  logic signed [SAMPLE_W-1:0] left_word,
  input  logic                       left_occ,
  input  logic signed [SAMPLE_W-1:0] right_word,
  input  logic                       right_occ,
  output logic signed [SAMPLE_W-1:0] word,
  output logic                       occ,
  output logic                       gt
);

  // The new word belongs at or before this cell when the cell is empty or holds a larger word.
  assign gt = !occ || (new_word < word);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.clear) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ  <= right_occ;
      word <= right_word;
    end else if (ctrl.insert && gt) begin
      if (left_gt) begin
        occ  <= left_occ;
        word <= left_word;
      end else begin
        occ  <= 1'b1;
        word <= new_word;
      end
    end
  end

endmodule

/* hw/rtl/kth_smallest_select_top.sv */
// Top level of the k-th smallest selector built on a sorted chain of cells.
//
// Usage: values arrive on the input channel (sample, last) under in_valid and
// in_stall, one word per cycle while a set loads. Each accepted word is put
// in sorted position in a chain of MAX_ITEMS cells in the same cycle, so the
// chain always holds the stored words in ascending order. Words that arrive
// when all cells are full are dropped and the set is marked as overflowed.
// The word with last set closes the set. After it the block stalls its input
// and shifts the chain toward cell 0 once per cycle, rank-1 times, so the
// requested word ends in cell 0. From there it moves into the output register
// once that register is free, and the chain is emptied. A rank that is zero or
// larger than the stored count gives rank_error and a zero result.
// Results leave on the output channel (selected, rank_error, overflow) under
// out_valid and out_stall. A stalled result holds in the output register; the
// next set may load meanwhile and its result waits until the register frees.
// The rank register is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; write it only while the block is idle.
// Synchronous reset empties the chain, clears the count, the overflow mark and
// out_valid, and sets rank to 1. No clearing pass is needed.
module kth_smallest_select_top import ksel_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [RANK_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] selected,
  output logic                       rank_error,
  output logic                       overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SEL_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  logic [RANK_W-1:0]  rank;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               overflow_seen;
  logic [SEL_W-1:0]   steps;
  logic               set_error;
  logic               set_overflow;
  ksel_state_t        state;
  ksel_ctrl_t         ctrl;

  logic               in_accept;
  logic               full;
  logic               err_now;
  logic               emit;

  logic signed [SAMPLE_W-1:0] cell_word [MAX_ITEMS];
  logic                       cell_occ  [MAX_ITEMS];
  logic                       cell_gt   [MAX_ITEMS];

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rank <= cfg_data;
    end
  end

  assign in_stall  = (state != ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign count_next = full ? count : count + CNT_W'(1);
  assign err_now   = (rank == '0) || (CMP_W'(rank) > CMP_W'(count_next));

  // The result leaves once no shifts remain and the output register is free.
  assign emit = (state == ST_SELECT) && (steps == '0) && (!out_valid || !out_stall);

  always_comb begin
    ctrl.insert = in_accept && !full;
    ctrl.shift  = (state == ST_SELECT) && (steps != '0) && !set_error;
    ctrl.clear  = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
      steps         <= '0;
      set_error     <= 1'b0;
      set_overflow  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            count         <= count_next;
            overflow_seen <= overflow_seen || full;
            if (last) begin
              state        <= ST_SELECT;
              set_error    <= err_now;
              set_overflow <= overflow_seen || full;
              steps        <= err_now ? '0 : SEL_W'(rank - RANK_W'(1));
            end
          end
        end
        ST_SELECT: begin
          if (emit) begin
            state         <= ST_LOAD;
            count         <= '0;
            overflow_seen <= 1'b0;
          end else if (steps != '0) begin
            steps <= steps - SEL_W'(1);
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      selected   <= set_error ? '0 : cell_word[0];
      rank_error <= set_error;
      overflow   <= set_overflow;
    end
  end

  // The chain: cell 0 holds the smallest word.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                       l_gt;
    logic signed [SAMPLE_W-1:0] l_word;
    logic                       l_occ;
    logic signed [SAMPLE_W-1:0] r_word;
    logic                       r_occ;

    if (i == 0) begin : g_first
      assign l_gt   = 1'b0;
      assign l_word = '0;
      assign l_occ  = 1'b0;
    end else begin : g_inner_l
      assign l_gt   = cell_gt[i-1];
      assign l_word = cell_word[i-1];
      assign l_occ  = cell_occ[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign r_word = '0;
      assign r_occ  = 1'b0;
    end else begin : g_inner_r
      assign r_word = cell_word[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    ksel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_word   (sample),
      .left_gt    (l_gt),
      .left_word  (l_word),
      .left_occ   (l_occ),
      .right_word (r_word),
      .right_occ  (r_occ),
      .word       (cell_word[i]),
      .occ        (cell_occ[i]),
      .gt         (cell_gt[i])
    );
  end

endmodule

/* hw/rtl/ksel_checker.sv */
// Port-level checker for the rank selector, bound to its top level.
module ksel_checker import ksel_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       cfg_ready,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] selected,
  input logic                       rank_error
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A closed set blocks input right after its last word is taken.
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) |=> in_stall)
    else $error("input taken right after the last word of a set");

  // An error result carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rank_error) |-> (selected == '0))
    else $error("rank error with nonzero value");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(selected)))
    else $error("stalled result changed");

  // The configuration port is always ready.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind kth_smallest_select_top ksel_checker u_ksel_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_ready  (cfg_ready),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last       (last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .selected   (selected),
  .rank_error (rank_error)
);
